### hdl/ecu_pkg.sv
// Shared constants and types of the easing curve unit
package ecu_pkg;

    localparam int POS_BITS_DEF   = 24;
    localparam int VALUE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int SINE_DEPTH_DEF = 256;

    localparam int CFG_INDEX_BITS = 3;
    localparam int MODE_BITS      = 3;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_LINEAR,
        MODE_SINE_IN,
        MODE_SINE_OUT,
        MODE_SINE_IN_OUT,
        MODE_QUAD,
        MODE_CUBIC
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CURVE_MODE,
        REG_START_POS,
        REG_END_POS,
        REG_START_VALUE,
        REG_END_VALUE,
        REG_CONTROL1,
        REG_CONTROL2
    } reg_index_t;

    typedef struct packed {
        logic valid;
        logic zero_span;
        logic clamp_lo;
        logic clamp_hi;
    } ecu_tag_t;

endpackage

### hdl/ecu_sine_rom.sv
// Quarter-wave sine table with registered read
module ecu_sine_rom #(
    parameter int FRAC_BITS        = ecu_pkg::FRAC_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = ecu_pkg::SINE_DEPTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      en,
    input  logic [$clog2(SINE_TABLE_DEPTH + 1) - 1:0] idx,
    output logic [FRAC_BITS:0]                        sine_reg
);
    import ecu_pkg::*;

    localparam longint HALF_PI_Q30 = 64'd1686629713;
    localparam longint ONE_L       = longint'(1) << FRAC_BITS;

    // sin(pi/2 * k / depth) by a Taylor series in Q30, rounded to Q1.FRAC_BITS
    function automatic logic [FRAC_BITS:0] sine_entry(input int k);
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] mag;
        longint      sum;
        longint      e;
        th  = (64'(k) * 64'(HALF_PI_Q30) + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
        th2 = (th * th + (64'd1 << 29)) >> 30;
        mag = th;
        sum = longint'(th);
        mag = ((mag * th2) >> 30) / 64'd6;   sum = sum - longint'(mag);
        mag = ((mag * th2) >> 30) / 64'd20;  sum = sum + longint'(mag);
        mag = ((mag * th2) >> 30) / 64'd42;  sum = sum - longint'(mag);
        mag = ((mag * th2) >> 30) / 64'd72;  sum = sum + longint'(mag);
        mag = ((mag * th2) >> 30) / 64'd110; sum = sum - longint'(mag);
        mag = ((mag * th2) >> 30) / 64'd156; sum = sum + longint'(mag);
        mag = ((mag * th2) >> 30) / 64'd210; sum = sum - longint'(mag);
        mag = ((mag * th2) >> 30) / 64'd272; sum = sum + longint'(mag);
        mag = ((mag * th2) >> 30) / 64'd342; sum = sum - longint'(mag);
        mag = ((mag * th2) >> 30) / 64'd420; sum = sum + longint'(mag);
        if (sum < 0)
        begin
            sum = 0;
        end
        e = (sum + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        if (e > ONE_L)
        begin
            e = ONE_L;
        end
        if (k == 0)
        begin
            e = 0;
        end
        if (k == SINE_TABLE_DEPTH)
        begin
            e = ONE_L;
        end
        return e[FRAC_BITS:0];
    endfunction

    logic [FRAC_BITS:0] table_w [SINE_TABLE_DEPTH + 1];

    genvar k;
    generate
        for (k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin : g_entry
            assign table_w[k] = sine_entry(k);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sine_reg <= table_w[idx];
        end
    end

endmodule

### hdl/ecu_div.sv
// Pipelined restoring divider giving the rounded, clamped curve parameter t
module ecu_div #(
    parameter int POS_BITS  = ecu_pkg::POS_BITS_DEF,
    parameter int FRAC_BITS = ecu_pkg::FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  ecu_pkg::ecu_tag_t       tag_in,
    input  logic [POS_BITS-1:0]     num,
    input  logic [POS_BITS-1:0]     span,
    output ecu_pkg::ecu_tag_t       tag_out_reg,
    output logic [FRAC_BITS:0]      t_reg
);
    import ecu_pkg::*;

    localparam int STEPS = FRAC_BITS + 1;
    localparam logic [FRAC_BITS:0] ONE_T = {1'b1, {FRAC_BITS{1'b0}}};

    logic [POS_BITS-1:0]  rem_reg  [STEPS];
    logic [POS_BITS-1:0]  span_reg [STEPS];
    logic [FRAC_BITS:0]   quo_reg  [STEPS];
    ecu_tag_t             tag_reg  [STEPS];

    genvar j;
    generate
        for (j = 0; j < STEPS; j++)
        begin : g_step
            logic [POS_BITS:0]   trial;
            logic [POS_BITS:0]   diff;
            logic [POS_BITS-1:0] span_prev;
            logic [FRAC_BITS:0]  quo_prev;
            ecu_tag_t            tag_prev;
            logic                bit_q;

            if (j == 0)
            begin : g_first
                // numerator never exceeds the span, so the top bit needs no shift
                assign trial     = {1'b0, num};
                assign span_prev = span;
                assign quo_prev  = '0;
                assign tag_prev  = tag_in;
            end
            else
            begin : g_next
                assign trial     = {rem_reg[j-1], 1'b0};
                assign span_prev = span_reg[j-1];
                assign quo_prev  = quo_reg[j-1];
                assign tag_prev  = tag_reg[j-1];
            end

            assign bit_q = (trial >= {1'b0, span_prev});
            assign diff  = trial - {1'b0, span_prev};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    tag_reg[j] <= '0;
                end
                else if (en)
                begin
                    tag_reg[j] <= tag_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j]  <= bit_q ? diff[POS_BITS-1:0] : trial[POS_BITS-1:0];
                    quo_reg[j]  <= {quo_prev[FRAC_BITS-1:0], bit_q};
                    span_reg[j] <= span_prev;
                end
            end
        end
    endgenerate

    // round half up: add one when remainder plus half the span reaches the span
    logic [POS_BITS:0]  rsum;
    logic               round_up;
    logic [FRAC_BITS:0] t_next;

    always_comb
    begin
        rsum     = {1'b0, rem_reg[STEPS-1]} + {2'b00, span_reg[STEPS-1][POS_BITS-1:1]};
        round_up = (rsum >= {1'b0, span_reg[STEPS-1]});
        if (tag_reg[STEPS-1].clamp_hi)
        begin
            t_next = ONE_T;
        end
        else if (tag_reg[STEPS-1].clamp_lo)
        begin
            t_next = '0;
        end
        else
        begin
            t_next = quo_reg[STEPS-1] + {{FRAC_BITS{1'b0}}, round_up};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_out_reg <= '0;
        end
        else if (en)
        begin
            tag_out_reg <= tag_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg <= t_next;
        end
    end

endmodule

### hdl/easing_curve_unit_top.sv
// Easing curve unit: position to curve value, fully pipelined
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | in_valid / in_stall   | x_pos
//  output   | out_valid / out_stall | curve_value, out_of_range, zero_span
//  config   | cfg_wr_en             | cfg_index, cfg_data
//
// One item enters per cycle unless a held result stalls the pipeline; the divider
// resolves one quotient bit per stage.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// A result held on out_stall freezes the whole pipeline; in_stall follows it.
module easing_curve_unit_top #(
    parameter int POS_BITS         = ecu_pkg::POS_BITS_DEF,
    parameter int VALUE_BITS       = ecu_pkg::VALUE_BITS_DEF,
    parameter int FRAC_BITS        = ecu_pkg::FRAC_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = ecu_pkg::SINE_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [ecu_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [((POS_BITS > VALUE_BITS) ? POS_BITS : VALUE_BITS) - 1:0] cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [POS_BITS-1:0]                   x_pos,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [VALUE_BITS-1:0]          curve_value,
    output logic                                  out_of_range,
    output logic                                  zero_span
);
    import ecu_pkg::*;

    localparam int TW    = FRAC_BITS + 1;
    localparam int IW    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int IXW   = FRAC_BITS + IW + 1;
    localparam int PW2   = 2 * FRAC_BITS + 2;
    localparam int PW3   = 2 * FRAC_BITS + 4;
    localparam int WW    = FRAC_BITS + 3;
    localparam int AW    = VALUE_BITS + 1;
    localparam int MW    = AW + WW;
    localparam int SW    = MW + 2;
    localparam int YW    = SW + 1;
    localparam int LANES = 4;

    localparam logic [TW-1:0]        ONE_T    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [WW-1:0] ONE_W    = $signed({2'b00, ONE_T});
    localparam logic [IXW-1:0]       IDX_HALF = IXW'(1) << (FRAC_BITS - 1);
    localparam logic [PW2-1:0]       HALF_P2  = PW2'(1) << (FRAC_BITS - 1);
    localparam logic [PW3-1:0]       HALF_P3  = PW3'(1) << (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] HALF_F   = SW'(1) << (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] HALF_F1  = SW'(1) << FRAC_BITS;
    localparam longint               Y_MAX_L  = (longint'(1) << (VALUE_BITS - 1)) - 1;
    localparam logic signed [YW-1:0] Y_MAX    = YW'(Y_MAX_L);
    localparam logic signed [YW-1:0] Y_MIN    = -Y_MAX - YW'(1);

    // ---------------- configuration registers ----------------
    logic [MODE_BITS-1:0]         mode_reg;
    logic [POS_BITS-1:0]          start_pos_reg;
    logic [POS_BITS-1:0]          end_pos_reg;
    logic signed [VALUE_BITS-1:0] start_value_reg;
    logic signed [VALUE_BITS-1:0] end_value_reg;
    logic signed [VALUE_BITS-1:0] control1_reg;
    logic signed [VALUE_BITS-1:0] control2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_LINEAR;
            start_pos_reg   <= '0;
            end_pos_reg     <= POS_BITS'(1);
            start_value_reg <= '0;
            end_value_reg   <= '0;
            control1_reg    <= '0;
            control2_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CURVE_MODE:  mode_reg        <= cfg_data[MODE_BITS-1:0];
                REG_START_POS:   start_pos_reg   <= cfg_data[POS_BITS-1:0];
                REG_END_POS:     end_pos_reg     <= cfg_data[POS_BITS-1:0];
                REG_START_VALUE: start_value_reg <= cfg_data[VALUE_BITS-1:0];
                REG_END_VALUE:   end_value_reg   <= cfg_data[VALUE_BITS-1:0];
                REG_CONTROL1:    control1_reg    <= cfg_data[VALUE_BITS-1:0];
                REG_CONTROL2:    control2_reg    <= cfg_data[VALUE_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // advance every stage unless a finished result is held
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // ---------------- stage 0: input register ----------------
    logic                s0_valid_reg;
    logic [POS_BITS-1:0] s0_x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_x_reg <= x_pos;
        end
    end

    // ---------------- stage 1: offset, span, clamping ----------------
    logic signed [POS_BITS:0] diff_c;
    logic signed [POS_BITS:0] spn_c;
    ecu_tag_t                 s1_tag_next;
    logic [POS_BITS-1:0]      s1_num_next;
    ecu_tag_t                 s1_tag_reg;
    logic [POS_BITS-1:0]      s1_num_reg;
    logic [POS_BITS-1:0]      s1_span_reg;

    always_comb
    begin
        diff_c = $signed({1'b0, s0_x_reg}) - $signed({1'b0, start_pos_reg});
        spn_c  = $signed({1'b0, end_pos_reg}) - $signed({1'b0, start_pos_reg});
        // reversed segment: measure from start toward end
        if (spn_c < 0)
        begin
            spn_c  = -spn_c;
            diff_c = -diff_c;
        end
        s1_tag_next.valid     = s0_valid_reg;
        s1_tag_next.zero_span = (spn_c == '0);
        s1_tag_next.clamp_lo  = !s1_tag_next.zero_span && (diff_c < 0);
        s1_tag_next.clamp_hi  = !s1_tag_next.zero_span && !s1_tag_next.clamp_lo
                                && (diff_c > spn_c);
        s1_num_next = (s1_tag_next.clamp_lo || s1_tag_next.clamp_hi)
                      ? '0 : diff_c[POS_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
        end
        else if (adv)
        begin
            s1_tag_reg <= s1_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_num_reg  <= s1_num_next;
            s1_span_reg <= spn_c[POS_BITS-1:0];
        end
    end

    // ---------------- divider ----------------
    ecu_tag_t      dv_tag;
    logic [TW-1:0] dv_t;

    ecu_div #(
        .POS_BITS  (POS_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .tag_in      (s1_tag_reg),
        .num         (s1_num_reg),
        .span        (s1_span_reg),
        .tag_out_reg (dv_tag),
        .t_reg       (dv_t)
    );

    // ---------------- stage 2: sine argument, squares ----------------
    logic [TW:0]     two_t_c;
    logic [TW-1:0]   u_c;
    logic [TW-1:0]   p_c;
    logic            neg_c;
    logic [IXW-1:0]  idx_full_c;

    ecu_tag_t        s2_tag_reg;
    logic [TW-1:0]   s2_t_reg;
    logic [TW-1:0]   s2_u_reg;
    logic            s2_neg_reg;
    logic [PW2-1:0]  s2_uu_reg;
    logic [PW2-1:0]  s2_tt_reg;
    logic [IW-1:0]   s2_idx_reg;

    always_comb
    begin
        two_t_c = {dv_t, 1'b0};
        u_c     = ONE_T - dv_t;
        if (two_t_c <= {1'b0, ONE_T})
        begin
            p_c   = ONE_T - two_t_c[TW-1:0];
            neg_c = 1'b0;
        end
        else
        begin
            p_c   = TW'(two_t_c - {1'b0, ONE_T});
            neg_c = 1'b1;
        end
        case (mode_reg)
            MODE_SINE_IN:  p_c = u_c;
            MODE_SINE_OUT: p_c = dv_t;
            default:       ;
        endcase
        // nearest table entry
        idx_full_c = IXW'(p_c) * IXW'(SINE_TABLE_DEPTH) + IDX_HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_tag_reg <= '0;
        end
        else if (adv)
        begin
            s2_tag_reg <= dv_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_t_reg   <= dv_t;
            s2_u_reg   <= u_c;
            s2_neg_reg <= neg_c;
            s2_uu_reg  <= PW2'(u_c) * PW2'(u_c);
            s2_tt_reg  <= PW2'(dv_t) * PW2'(dv_t);
            s2_idx_reg <= idx_full_c[FRAC_BITS +: IW];
        end
    end

    // ---------------- stage 3: table read, rounded squares ----------------
    logic [TW-1:0]  s3_sine;
    logic [PW2-1:0] uu_rnd_c;
    logic [PW2-1:0] tt_rnd_c;

    ecu_tag_t       s3_tag_reg;
    logic [TW-1:0]  s3_t_reg;
    logic [TW-1:0]  s3_u_reg;
    logic           s3_neg_reg;
    logic [TW-1:0]  s3_u2_reg;
    logic [TW-1:0]  s3_t2_reg;

    ecu_sine_rom #(
        .FRAC_BITS        (FRAC_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .clk      (clk),
        .en       (adv),
        .idx      (s2_idx_reg),
        .sine_reg (s3_sine)
    );

    assign uu_rnd_c = s2_uu_reg + HALF_P2;
    assign tt_rnd_c = s2_tt_reg + HALF_P2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_tag_reg <= '0;
        end
        else if (adv)
        begin
            s3_tag_reg <= s2_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_t_reg   <= s2_t_reg;
            s3_u_reg   <= s2_u_reg;
            s3_neg_reg <= s2_neg_reg;
            s3_u2_reg  <= uu_rnd_c[FRAC_BITS +: TW];
            s3_t2_reg  <= tt_rnd_c[FRAC_BITS +: TW];
        end
    end

    // ---------------- stage 4: cubic products ----------------
    ecu_tag_t       s4_tag_reg;
    logic [TW-1:0]  s4_t_reg;
    logic           s4_neg_reg;
    logic [TW-1:0]  s4_sine_reg;
    logic [TW-1:0]  s4_u2_reg;
    logic [TW-1:0]  s4_t2_reg;
    logic [PW2-1:0] s4_pa_reg;
    logic [PW3-1:0] s4_pb_reg;
    logic [PW3-1:0] s4_pc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_tag_reg <= '0;
        end
        else if (adv)
        begin
            s4_tag_reg <= s3_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_t_reg    <= s3_t_reg;
            s4_neg_reg  <= s3_neg_reg;
            s4_sine_reg <= s3_sine;
            s4_u2_reg   <= s3_u2_reg;
            s4_t2_reg   <= s3_t2_reg;
            s4_pa_reg   <= PW2'(s3_u2_reg) * PW2'(s3_u_reg);
            s4_pb_reg   <= PW3'(3) * PW3'(s3_t_reg) * PW3'(s3_u2_reg);
            s4_pc_reg   <= PW3'(3) * PW3'(s3_t2_reg) * PW3'(s3_u_reg);
        end
    end

    // ---------------- stage 5: weights and lane values ----------------
    logic [PW2-1:0]               pa_rnd_c;
    logic [PW3-1:0]               pb_rnd_c;
    logic [PW3-1:0]               pc_rnd_c;
    logic signed [WW-1:0]         sine_s_c;
    logic signed [WW-1:0]         cos_s_c;
    logic signed [AW-1:0]         d_c;
    logic signed [WW-1:0]         w_c [LANES];
    logic signed [AW-1:0]         a_c [LANES];
    logic signed [VALUE_BITS-1:0] base_c;
    logic                         wide_c;

    ecu_tag_t                     s5_tag_reg;
    logic signed [WW-1:0]         s5_w_reg [LANES];
    logic signed [AW-1:0]         s5_a_reg [LANES];
    logic signed [VALUE_BITS-1:0] s5_base_reg;
    logic                         s5_wide_reg;

    always_comb
    begin
        pa_rnd_c = s4_pa_reg + HALF_P2;
        pb_rnd_c = s4_pb_reg + HALF_P3;
        pc_rnd_c = s4_pc_reg + HALF_P3;
        sine_s_c = $signed(WW'(s4_sine_reg));
        cos_s_c  = s4_neg_reg ? -sine_s_c : sine_s_c;
        d_c      = AW'(end_value_reg) - AW'(start_value_reg);
        for (int i = 0; i < LANES; i++)
        begin
            w_c[i] = '0;
            a_c[i] = '0;
        end
        a_c[0] = d_c;
        base_c = start_value_reg;
        wide_c = 1'b0;
        case (mode_reg)
            MODE_SINE_IN:
            begin
                w_c[0] = ONE_W - sine_s_c;
            end
            MODE_SINE_OUT:
            begin
                w_c[0] = sine_s_c;
            end
            MODE_SINE_IN_OUT:
            begin
                w_c[0] = ONE_W - cos_s_c;
                wide_c = 1'b1;
            end
            MODE_QUAD:
            begin
                w_c[0] = $signed(WW'(s4_u2_reg));
                w_c[2] = $signed(WW'(s4_t2_reg));
                w_c[1] = ONE_W - w_c[0] - w_c[2];
                a_c[0] = AW'(start_value_reg);
                a_c[1] = AW'(control1_reg);
                a_c[2] = AW'(end_value_reg);
                base_c = '0;
            end
            MODE_CUBIC:
            begin
                w_c[0] = $signed(WW'(pa_rnd_c[PW2-1:FRAC_BITS]));
                w_c[1] = $signed(WW'(pb_rnd_c[PW3-1:FRAC_BITS]));
                w_c[2] = $signed(WW'(pc_rnd_c[PW3-1:FRAC_BITS]));
                w_c[3] = ONE_W - w_c[0] - w_c[1] - w_c[2];
                a_c[0] = AW'(start_value_reg);
                a_c[1] = AW'(control1_reg);
                a_c[2] = AW'(control2_reg);
                a_c[3] = AW'(end_value_reg);
                base_c = '0;
            end
            default:
            begin
                w_c[0] = $signed(WW'(s4_t_reg));
            end
        endcase
        // zero span: drop all weights, leave the start value
        if (s4_tag_reg.zero_span)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                w_c[i] = '0;
            end
            base_c = start_value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_tag_reg <= '0;
        end
        else if (adv)
        begin
            s5_tag_reg <= s4_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                s5_w_reg[i] <= w_c[i];
                s5_a_reg[i] <= a_c[i];
            end
            s5_base_reg <= base_c;
            s5_wide_reg <= wide_c;
        end
    end

    // ---------------- stage 6: lane products ----------------
    ecu_tag_t                     s6_tag_reg;
    logic signed [MW-1:0]         s6_m_reg [LANES];
    logic signed [VALUE_BITS-1:0] s6_base_reg;
    logic                         s6_wide_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_tag_reg <= '0;
        end
        else if (adv)
        begin
            s6_tag_reg <= s5_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                s6_m_reg[i] <= MW'(s5_w_reg[i]) * MW'(s5_a_reg[i]);
            end
            s6_base_reg <= s5_base_reg;
            s6_wide_reg <= s5_wide_reg;
        end
    end

    // ---------------- stage 7: pair sums ----------------
    ecu_tag_t                     s7_tag_reg;
    logic signed [SW-1:0]         s7_s01_reg;
    logic signed [SW-1:0]         s7_s23_reg;
    logic signed [VALUE_BITS-1:0] s7_base_reg;
    logic                         s7_wide_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_tag_reg <= '0;
        end
        else if (adv)
        begin
            s7_tag_reg <= s6_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_s01_reg  <= SW'(s6_m_reg[0]) + SW'(s6_m_reg[1]);
            s7_s23_reg  <= SW'(s6_m_reg[2]) + SW'(s6_m_reg[3]);
            s7_base_reg <= s6_base_reg;
            s7_wide_reg <= s6_wide_reg;
        end
    end

    // ---------------- stage 8: total plus rounding offset ----------------
    ecu_tag_t                     s8_tag_reg;
    logic signed [SW-1:0]         s8_acc_reg;
    logic signed [VALUE_BITS-1:0] s8_base_reg;
    logic                         s8_wide_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_tag_reg <= '0;
        end
        else if (adv)
        begin
            s8_tag_reg <= s7_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_acc_reg  <= s7_s01_reg + s7_s23_reg + (s7_wide_reg ? HALF_F1 : HALF_F);
            s8_base_reg <= s7_base_reg;
            s8_wide_reg <= s7_wide_reg;
        end
    end

    // ---------------- output stage: shift, add base, saturate ----------------
    logic signed [SW-1:0] shifted_c;
    logic signed [YW-1:0] y_c;
    logic signed [YW-1:0] y_sat_c;

    always_comb
    begin
        shifted_c = s8_wide_reg ? (s8_acc_reg >>> (FRAC_BITS + 1)) : (s8_acc_reg >>> FRAC_BITS);
        y_c       = YW'(s8_base_reg) + YW'(shifted_c);
        if (y_c > Y_MAX)
        begin
            y_sat_c = Y_MAX;
        end
        else if (y_c < Y_MIN)
        begin
            y_sat_c = Y_MIN;
        end
        else
        begin
            y_sat_c = y_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            out_valid <= s8_tag_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            curve_value  <= y_sat_c[VALUE_BITS-1:0];
            out_of_range <= s8_tag_reg.clamp_lo || s8_tag_reg.clamp_hi;
            zero_span    <= s8_tag_reg.zero_span;
        end
    end

endmodule

### test/ecu_checker.sv
// Checker for the easing curve unit: predicts each transfer and compares results
`timescale 1ns / 1ps

module ecu_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [23:0]         x_pos,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic signed [23:0]  curve_value,
    input  logic                out_of_range,
    input  logic                zero_span,
    output int                  fail_count,
    output int                  pending
);
    import ecu_pkg::*;

    localparam longint ONE = 64'sd65536;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef struct packed {
        logic [23:0] value;
        logic        oor;
        logic        zs;
    } curve_point_t;

    longint      sine_lut [0:256];
    logic [2:0]  mode_r;
    logic [23:0] spos_r, epos_r, sval_r, eval_r, c1_r, c2_r;
    curve_point_t expected_points [$];

    // arithmetic round of v by s bits, floor of (v + half)
    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint sx24(logic [23:0] r);
        return longint'($signed(r));
    endfunction

    function automatic void build_sine_lut();
        longint unsigned th, th2, mag;
        longint sum, e;
        for (int k = 0; k <= 256; k++)
        begin
            th = (longint'(k) * HALF_PI_Q30 + 128) / 256;
            th2 = (th * th + (64'd1 << 29)) >> 30;
            mag = th;
            sum = th;
            for (int n = 1; n <= 10; n++)
            begin
                mag = ((mag * th2) >> 30) / ((2 * n) * (2 * n + 1));
                sum = (n & 1) ? sum - longint'(mag) : sum + longint'(mag);
            end
            if (sum < 0) sum = 0;
            e = round_shift(sum, 14);
            if (e > ONE) e = ONE;
            sine_lut[k] = e;
        end
        sine_lut[0] = 0;
        sine_lut[256] = ONE;
    endfunction

    function automatic longint quarter_sine(longint p);
        longint idx;
        if (p < 0) p = 0;
        if (p > ONE) p = ONE;
        idx = (p * 256 + 32768) >>> 16;
        if (idx > 256) idx = 256;
        return sine_lut[idx];
    endfunction

    function automatic curve_point_t evaluate_curve(logic [23:0] x);
        curve_point_t r;
        longint num, span, ay, by, c1, c2, d, t, u, y, c, w0, w1, w2, w3, u2, t2;
        num = longint'(x) - longint'(spos_r);
        span = longint'(epos_r) - longint'(spos_r);
        ay = sx24(sval_r);
        by = sx24(eval_r);
        c1 = sx24(c1_r);
        c2 = sx24(c2_r);
        d = by - ay;
        r.oor = 1'b0;
        r.zs = 1'b0;
        if (span == 0)
        begin
            r.zs = 1'b1;
            y = ay;
        end
        else
        begin
            if (span < 0)
            begin
                span = -span;
                num = -num;
            end
            if (num < 0)
            begin
                t = 0;
                r.oor = 1'b1;
            end
            else if (num > span)
            begin
                t = ONE;
                r.oor = 1'b1;
            end
            else
                t = ((num <<< 16) + span / 2) / span;
            u = ONE - t;
            case (mode_r)
                MODE_SINE_IN:  y = ay + round_shift(d * (ONE - quarter_sine(u)), 16);
                MODE_SINE_OUT: y = ay + round_shift(d * quarter_sine(t), 16);
                MODE_SINE_IN_OUT:
                begin
                    c = (2 * t <= ONE) ? quarter_sine(ONE - 2 * t)
                                       : -quarter_sine(2 * t - ONE);
                    y = ay + round_shift(d * (ONE - c), 17);
                end
                MODE_QUAD:
                begin
                    w0 = round_shift(u * u, 16);
                    w2 = round_shift(t * t, 16);
                    w1 = ONE - w0 - w2;
                    y = round_shift(w0 * ay + w1 * c1 + w2 * by, 16);
                end
                MODE_CUBIC:
                begin
                    u2 = round_shift(u * u, 16);
                    t2 = round_shift(t * t, 16);
                    w0 = round_shift(u2 * u, 16);
                    w1 = round_shift(3 * t * u2, 16);
                    w2 = round_shift(3 * t2 * u, 16);
                    w3 = ONE - w0 - w1 - w2;
                    y = round_shift(w0 * ay + w1 * c1 + w2 * c2 + w3 * by, 16);
                end
                default:       y = ay + round_shift(d * t, 16);
            endcase
        end
        if (y > 8388607) y = 8388607;
        if (y < -8388608) y = -8388608;
        r.value = y[23:0];
        return r;
    endfunction

    initial
    begin
        build_sine_lut();
    end

    assign pending = expected_points.size();

    always @(posedge clk or negedge rst_n)
    begin
        curve_point_t exp_pt;
        if (!rst_n)
        begin
            mode_r <= MODE_LINEAR;
            spos_r <= '0;
            epos_r <= 24'd1;
            sval_r <= '0;
            eval_r <= '0;
            c1_r <= '0;
            c2_r <= '0;
            fail_count <= 0;
            expected_points.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result transfer value=%0d", curve_value);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_pt = expected_points.pop_front();
                    if (exp_pt.value !== curve_value || exp_pt.oor !== out_of_range
                        || exp_pt.zs !== zero_span)
                    begin
                        if (fail_count < 10)
                            $display("ERROR: expected value=%0d oor=%0b zs=%0b, got %0d %0b %0b",
                                     $signed(exp_pt.value), exp_pt.oor, exp_pt.zs,
                                     curve_value, out_of_range, zero_span);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // predict with the registers as they stand before this edge's write
            if (in_valid && !in_stall)
                expected_points.push_back(evaluate_curve(x_pos));
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_CURVE_MODE:  mode_r <= cfg_data[2:0];
                    REG_START_POS:   spos_r <= cfg_data;
                    REG_END_POS:     epos_r <= cfg_data;
                    REG_START_VALUE: sval_r <= cfg_data;
                    REG_END_VALUE:   eval_r <= cfg_data;
                    REG_CONTROL1:    c1_r <= cfg_data;
                    REG_CONTROL2:    c2_r <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

### test/tb_top.sv
// Top of the easing curve unit testbench: stimulus, configuration and verdict
`timescale 1ns / 1ps

module tb_top;
    import ecu_pkg::*;

    localparam int LATENCY = 28;
    localparam int RANDOM_ITEMS = 1150;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [23:0] x_pos;
    logic        out_valid;
    logic        out_stall;
    logic signed [23:0] curve_value;
    logic        out_of_range;
    logic        zero_span;
    int          fail_count;
    int          pending;
    int          phases_run;
    int          items_sent;

    easing_curve_unit_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .x_pos(x_pos),
        .out_valid(out_valid), .out_stall(out_stall),
        .curve_value(curve_value), .out_of_range(out_of_range), .zero_span(zero_span)
    );

    ecu_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .x_pos(x_pos),
        .out_valid(out_valid), .out_stall(out_stall),
        .curve_value(curve_value), .out_of_range(out_of_range), .zero_span(zero_span),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("Verification failed");
        $finish;
    end

    // receiver: random stall stretches, none after some transfers
    initial
    begin
        int gap;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                if (gap > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // hold the enable; the caller drops it after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // hold until every expected result has arrived and the pipe is empty
    task automatic drain_pipe();
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic send_position(input logic [23:0] x, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        x_pos <= x;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
    endtask

    function automatic logic [23:0] rand_value(input int style);
        case (style)
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic configure(input logic [2:0] mode, input logic [23:0] sp,
                             input logic [23:0] ep, input logic [23:0] sv,
                             input logic [23:0] ev, input logic [23:0] c1,
                             input logic [23:0] c2);
        write_reg(REG_CURVE_MODE, mode);
        write_reg(REG_START_POS, sp);
        write_reg(REG_END_POS, ep);
        write_reg(REG_START_VALUE, sv);
        write_reg(REG_END_VALUE, ev);
        write_reg(REG_CONTROL1, c1);
        write_reg(REG_CONTROL2, c2);
        cfg_wr_en <= 1'b0;
        phases_run++;
    endtask

    initial
    begin
        logic [23:0] sp, ep, span, x;
        int gap, sel, burst;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        x_pos = '0;
        phases_run = 0;
        items_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: segment 0..1 with zero values
        send_position(24'd0, 0);
        send_position(24'd1, 0);
        send_position(24'hFFFFFF, 0);
        end_burst();
        drain_pipe();

        // directed: every mode code at full-range extremes, at the midpoint and just past both ends
        for (int m = 0; m < 8; m++)
        begin
            configure(m[2:0], 24'd1000, 24'd2000, 24'h800000, 24'h7FFFFF,
                      24'h7FFFFF, 24'h800000);
            send_position(24'd999, 0);
            send_position(24'd1500, 0);
            send_position(24'd2001, 0);
            end_burst();
            drain_pipe();
        end
        // reversed segment, zero span, full position range
        configure(MODE_CUBIC, 24'hFFFFFF, 24'd0, 24'h7FFFFF, 24'h800000, 24'h800000,
                  24'h7FFFFF);
        send_position(24'h000000, 0);
        send_position(24'h800000, 0);
        send_position(24'hFFFFFF, 0);
        end_burst();
        drain_pipe();
        configure(MODE_SINE_IN_OUT, 24'd500, 24'd500, 24'h123456, 24'h654321, 24'd0, 24'd0);
        send_position(24'd500, 0);
        send_position(24'd7, 0);
        end_burst();
        drain_pipe();

        // random phases: mostly in-segment positions, some outside
        while (items_sent < RANDOM_ITEMS - 40)
        begin
            sp = ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'($urandom_range(0, 65535));
            span = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4000));
            ep = ($urandom_range(0, 1) == 0) ? sp + span : sp - span;
            configure(3'($urandom_range(0, 7)), sp, ep, rand_value($urandom_range(0, 6)),
                      rand_value($urandom_range(0, 6)), rand_value($urandom_range(0, 6)),
                      rand_value($urandom_range(0, 6)));
            burst = $urandom_range(20, 80);
            for (int i = 0; i < burst; i++)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    x = (ep >= sp) ? sp + 24'($urandom_range(0, ep - sp))
                                   : ep + 24'($urandom_range(0, sp - ep));
                else if (sel < 9)
                    x = 24'($urandom);
                else
                    x = ($urandom_range(0, 1) == 0) ? sp - 1 : ep + 1;
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
                send_position(x, gap);
            end
            end_burst();
            drain_pipe();
        end

        drain_pipe();
        $display("Run covered %0d positions over %0d register settings in all curve modes,",
                 items_sent, phases_run);
        $display("including clamped, reversed and zero-span segments and saturating values.");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
